@@ rtl/core/rth_pkg.sv @@
// Shared types, constants and width helpers for the ray/triangle hit block.
// No dependencies; rth_front, rth_back and ray_triangle_hit_distance import this package.
package rth_pkg;

    localparam int IN_W   = 32;
    localparam int DIR_W  = 18;
    localparam int DIST_W = 32;
    localparam int NRM_W  = 64;
    localparam int CFG_IW = 3;

    localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
    localparam logic [NRM_W-1:0]  NRM_MAX  = {1'b0, {(NRM_W-1){1'b1}}};
    localparam logic [NRM_W-1:0]  NRM_MIN  = {1'b1, {(NRM_W-1){1'b0}}};

    localparam logic [IN_W-1:0]  ORG_RST   = '0;
    localparam logic [DIR_W-1:0] DIR_ONE   = 18'sd65536;
    localparam logic [DIR_W-1:0] DIR_ZERO  = '0;

    // Neighbor indexes for the cross product terms.
    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    typedef enum logic [CFG_IW-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_DIR_X    = 3'd3,
        CFG_DIR_Y    = 3'd4,
        CFG_DIR_Z    = 3'd5
    } t_cfg_idx;

    function automatic int edge_w(input int cw);
        return cw + 1;
    endfunction

    function automatic int det_w(input int cw);
        return 2 * cw + DIR_W + 5;
    endfunction

    function automatic int num_w(input int cw);
        return 3 * cw + 6;
    endfunction

endpackage

@@ rtl/core/ray_triangle_hit_distance.sv @@
// Ray/triangle hit distance unit.
//
// The user must write the ray through the configuration channel (i_cfg_valid,
// o_cfg_ready, i_cfg_index, i_cfg_data) only while the unit is idle; the unit
// does not enforce this. o_cfg_ready is always high and indexes beyond the
// direction registers are ignored. Reset loads origin zero, direction +x.
// Triangles enter as a queue write: a transfer happens when push is high and
// full is low. Results leave as a queue read: the oldest result is on the
// output ports while empty is low, and pop takes it.
// One triangle is accepted per cycle while full is low. A result passes
// through the front pipeline of products and sums, the middle queue, an
// input register, a 32 stage restoring divider with one quotient bit per
// stage, a saturation stage and the output queue.
// When the reader stops popping, the output queue fills, the divider pipeline
// holds, the middle queue fills, and full rises; no result is dropped.
// Depends on rth_pkg, rth_fifo, rth_front and rth_back.
module ray_triangle_hit_distance
    import rth_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IW-1:0]        i_cfg_index,
    input  logic [IN_W-1:0]          i_cfg_data,
    input  logic                     push,
    output logic                     full,
    input  logic signed [IN_W-1:0]   i_a_x,
    input  logic signed [IN_W-1:0]   i_a_y,
    input  logic signed [IN_W-1:0]   i_a_z,
    input  logic signed [IN_W-1:0]   i_b_x,
    input  logic signed [IN_W-1:0]   i_b_y,
    input  logic signed [IN_W-1:0]   i_b_z,
    input  logic signed [IN_W-1:0]   i_c_x,
    input  logic signed [IN_W-1:0]   i_c_y,
    input  logic signed [IN_W-1:0]   i_c_z,
    output logic                     empty,
    input  logic                     pop,
    output logic                     o_hit,
    output logic signed [DIST_W-1:0] o_distance,
    output logic signed [NRM_W-1:0]  o_normal_x,
    output logic signed [NRM_W-1:0]  o_normal_y,
    output logic signed [NRM_W-1:0]  o_normal_z
);

    localparam int CW   = COORD_WIDTH;
    localparam int DETW = det_w(CW);
    localparam int NUMW = num_w(CW);
    localparam int MIDW = 2 + DETW + NUMW + 3 * NRM_W;
    localparam int OUTW = 1 + DIST_W + 3 * NRM_W;

    logic [IN_W-1:0]  r_org [3];
    logic [DIR_W-1:0] r_dir [3];

    logic signed [CW-1:0]    org [3];
    logic signed [DIR_W-1:0] dir [3];
    logic signed [CW-1:0]    va [3];
    logic signed [CW-1:0]    vb [3];
    logic signed [CW-1:0]    vc [3];

    logic                    f_valid;
    logic                    f_hit;
    logic                    f_sign;
    logic [DETW-1:0]         f_det;
    logic [NUMW-1:0]         f_mag;
    logic signed [NRM_W-1:0] f_nrm [3];

    logic                    m_full;
    logic                    m_empty;
    logic                    m_pop;
    logic [MIDW-1:0]         m_wdata;
    logic [MIDW-1:0]         m_rdata;
    logic signed [NRM_W-1:0] m_nrm [3];

    logic                    b_valid;
    logic                    b_hit;
    logic [DIST_W-1:0]       b_dist;
    logic signed [NRM_W-1:0] b_nrm [3];

    logic                    o_q_full;
    logic [OUTW-1:0]         o_q_wdata;
    logic [OUTW-1:0]         o_q_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= ORG_RST;
            r_org[1] <= ORG_RST;
            r_org[2] <= ORG_RST;
            r_dir[0] <= DIR_ONE;
            r_dir[1] <= DIR_ZERO;
            r_dir[2] <= DIR_ZERO;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X: r_org[0] <= i_cfg_data;
                CFG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                CFG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                CFG_DIR_X:    r_dir[0] <= i_cfg_data[DIR_W-1:0];
                CFG_DIR_Y:    r_dir[1] <= i_cfg_data[DIR_W-1:0];
                CFG_DIR_Z:    r_dir[2] <= i_cfg_data[DIR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            org[i] = r_org[i][CW-1:0];
            dir[i] = r_dir[i];
        end
        va[0] = i_a_x[CW-1:0];
        va[1] = i_a_y[CW-1:0];
        va[2] = i_a_z[CW-1:0];
        vb[0] = i_b_x[CW-1:0];
        vb[1] = i_b_y[CW-1:0];
        vb[2] = i_b_z[CW-1:0];
        vc[0] = i_c_x[CW-1:0];
        vc[1] = i_c_y[CW-1:0];
        vc[2] = i_c_z[CW-1:0];
    end

    rth_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_a      (va),
        .i_b      (vb),
        .i_c      (vc),
        .i_org    (org),
        .i_dir    (dir),
        .o_valid  (f_valid),
        .i_q_full (m_full),
        .o_hit    (f_hit),
        .o_sign   (f_sign),
        .o_det    (f_det),
        .o_mag    (f_mag),
        .o_nrm    (f_nrm)
    );

    assign m_wdata = {f_hit, f_sign, f_det, f_mag, f_nrm[0], f_nrm[1], f_nrm[2]};

    rth_fifo #(
        .WIDTH(MIDW),
        .DEPTH(4)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid && !m_full),
        .i_data  (m_wdata),
        .o_full  (m_full),
        .i_pop   (m_pop),
        .o_data  (m_rdata),
        .o_empty (m_empty)
    );

    always_comb begin
        m_nrm[0] = m_rdata[3*NRM_W-1:2*NRM_W];
        m_nrm[1] = m_rdata[2*NRM_W-1:NRM_W];
        m_nrm[2] = m_rdata[NRM_W-1:0];
    end

    rth_back #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (m_empty),
        .o_pop      (m_pop),
        .i_hit      (m_rdata[MIDW-1]),
        .i_sign     (m_rdata[MIDW-2]),
        .i_det      (m_rdata[MIDW-3:NUMW+3*NRM_W]),
        .i_mag      (m_rdata[NUMW+3*NRM_W-1:3*NRM_W]),
        .i_nrm      (m_nrm),
        .o_valid    (b_valid),
        .i_out_full (o_q_full),
        .o_hit      (b_hit),
        .o_distance (b_dist),
        .o_nrm      (b_nrm)
    );

    assign o_q_wdata = {b_hit, b_dist, b_nrm[0], b_nrm[1], b_nrm[2]};

    rth_fifo #(
        .WIDTH(OUTW),
        .DEPTH(2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_valid && !o_q_full),
        .i_data  (o_q_wdata),
        .o_full  (o_q_full),
        .i_pop   (pop),
        .o_data  (o_q_rdata),
        .o_empty (empty)
    );

    assign o_hit      = o_q_rdata[OUTW-1];
    assign o_distance = o_q_rdata[OUTW-2:3*NRM_W];
    assign o_normal_x = o_q_rdata[3*NRM_W-1:2*NRM_W];
    assign o_normal_y = o_q_rdata[2*NRM_W-1:NRM_W];
    assign o_normal_z = o_q_rdata[NRM_W-1:0];

endmodule

@@ rtl/core/rth_fifo.sv @@
// Small first-in first-out queue of registers with full and empty flags.
// Depends on nothing; DEPTH must be a power of two, at least two.
module rth_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wr;
    logic [AW:0]      r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[AW] != r_rd[AW]) && (r_wr[AW-1:0] == r_rd[AW-1:0]);
    assign o_data  = r_mem[r_rd[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr[AW-1:0]] <= i_data;
        end
    end

endmodule

@@ rtl/core/rth_front.sv @@
// Geometry pipeline: edges, cross and dot products, hit classification.
// Depends on rth_pkg; feeds the numerator, determinant and normal to the queue.
module rth_front
    import rth_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_push,
    output logic                                    o_full,
    input  logic signed [COORD_WIDTH-1:0]           i_a [3],
    input  logic signed [COORD_WIDTH-1:0]           i_b [3],
    input  logic signed [COORD_WIDTH-1:0]           i_c [3],
    input  logic signed [COORD_WIDTH-1:0]           i_org [3],
    input  logic signed [DIR_W-1:0]                 i_dir [3],
    output logic                                    o_valid,
    input  logic                                    i_q_full,
    output logic                                    o_hit,
    output logic                                    o_sign,
    output logic [det_w(COORD_WIDTH)-1:0]           o_det,
    output logic [num_w(COORD_WIDTH)-1:0]           o_mag,
    output logic signed [NRM_W-1:0]                 o_nrm [3]
);

    localparam int CW   = COORD_WIDTH;
    localparam int EW   = edge_w(CW);
    localparam int DW   = DIR_W;
    localparam int PW   = DW + EW + 1;
    localparam int QW   = 2 * EW + 1;
    localparam int NW   = 2 * EW + 1;
    localparam int PL   = PW / 2;
    localparam int PH   = PW - PL;
    localparam int QL   = QW / 2;
    localparam int QH   = QW - QL;
    localparam int DETW = det_w(CW);
    localparam int NUMW = num_w(CW);
    localparam int HW   = DETW + 1;
    localparam int SW   = (NW > NRM_W) ? NW : NRM_W;
    localparam int NSTG = 8;

    logic [NSTG-1:0] r_vld;
    logic            en;

    logic signed [CW-1:0]       r_a [3];
    logic signed [CW-1:0]       r_b [3];
    logic signed [CW-1:0]       r_c [3];
    logic signed [EW-1:0]       r_e1 [1:3][3];
    logic signed [EW-1:0]       r_e2 [1:3][3];
    logic signed [EW-1:0]       r_t  [1:3][3];
    logic signed [DW+EW-1:0]    r_pa [3];
    logic signed [DW+EW-1:0]    r_pb [3];
    logic signed [2*EW-1:0]     r_qa [3];
    logic signed [2*EW-1:0]     r_qb [3];
    logic signed [2*EW-1:0]     r_na [3];
    logic signed [2*EW-1:0]     r_nb [3];
    logic signed [PW-1:0]       r_p [3];
    logic signed [QW-1:0]       r_q [3];
    logic signed [NW-1:0]       r_n [3];
    logic signed [EW+PL:0]      r_dl [3];
    logic signed [EW+PH-1:0]    r_dh [3];
    logic signed [EW+PL:0]      r_ul [3];
    logic signed [EW+PH-1:0]    r_uh [3];
    logic signed [DW+QL:0]      r_vl [3];
    logic signed [DW+QH-1:0]    r_vh [3];
    logic signed [EW+QL:0]      r_ml [3];
    logic signed [EW+QH-1:0]    r_mh [3];
    logic signed [EW+PW-1:0]    r_dp [3];
    logic signed [EW+PW-1:0]    r_up [3];
    logic signed [DW+QW-1:0]    r_vp [3];
    logic signed [EW+QW-1:0]    r_mp [3];
    logic signed [DETW-1:0]     r_det6;
    logic signed [DETW-1:0]     r_u6;
    logic signed [DETW-1:0]     r_v6;
    logic signed [NUMW-1:0]     r_num6;
    logic signed [NRM_W-1:0]    r_nrm [4:7][3];
    logic                       r_hit7;
    logic                       r_sign7;
    logic [DETW-1:0]            r_det7;
    logic [NUMW-1:0]            r_mag7;

    logic signed [HW-1:0]       uv;
    logic                       hit6;

    function automatic logic signed [NRM_W-1:0] sat_nrm(input logic signed [NW-1:0] x);
        logic signed [SW-1:0] xe;
        logic signed [SW-1:0] hi;
        xe = SW'(x);
        hi = xe >>> (NRM_W - 1);
        if (hi == '0 || hi == '1) begin
            return xe[NRM_W-1:0];
        end
        return xe[SW-1] ? NRM_MIN : NRM_MAX;
    endfunction

    assign en      = !(r_vld[NSTG-1] && i_q_full);
    assign o_full  = !en;
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_push};
        end
    end

    always_comb begin
        uv   = HW'(r_u6) + HW'(r_v6);
        hit6 = !r_det6[DETW-1] && (r_det6 != '0) && !r_u6[DETW-1] && (r_u6 <= r_det6)
               && !r_v6[DETW-1] && (uv <= HW'(r_det6));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= i_a[i];
                r_b[i] <= i_b[i];
                r_c[i] <= i_c[i];

                r_e1[1][i] <= EW'(r_b[i]) - EW'(r_a[i]);
                r_e2[1][i] <= EW'(r_c[i]) - EW'(r_a[i]);
                r_t[1][i]  <= EW'(i_org[i]) - EW'(r_a[i]);

                r_e1[2][i] <= r_e1[1][i];
                r_e2[2][i] <= r_e2[1][i];
                r_t[2][i]  <= r_t[1][i];
                r_e1[3][i] <= r_e1[2][i];
                r_e2[3][i] <= r_e2[2][i];
                r_t[3][i]  <= r_t[2][i];

                r_pa[i] <= i_dir[NXT[i]] * r_e2[1][PRV[i]];
                r_pb[i] <= i_dir[PRV[i]] * r_e2[1][NXT[i]];
                r_qa[i] <= r_t[1][NXT[i]] * r_e1[1][PRV[i]];
                r_qb[i] <= r_t[1][PRV[i]] * r_e1[1][NXT[i]];
                r_na[i] <= r_e1[1][NXT[i]] * r_e2[1][PRV[i]];
                r_nb[i] <= r_e1[1][PRV[i]] * r_e2[1][NXT[i]];

                r_p[i] <= PW'(r_pa[i]) - PW'(r_pb[i]);
                r_q[i] <= QW'(r_qa[i]) - QW'(r_qb[i]);
                r_n[i] <= NW'(r_na[i]) - NW'(r_nb[i]);

                r_dl[i] <= r_e1[3][i] * $signed({1'b0, r_p[i][PL-1:0]});
                r_dh[i] <= r_e1[3][i] * $signed(r_p[i][PW-1:PL]);
                r_ul[i] <= r_t[3][i] * $signed({1'b0, r_p[i][PL-1:0]});
                r_uh[i] <= r_t[3][i] * $signed(r_p[i][PW-1:PL]);
                r_vl[i] <= i_dir[i] * $signed({1'b0, r_q[i][QL-1:0]});
                r_vh[i] <= i_dir[i] * $signed(r_q[i][QW-1:QL]);
                r_ml[i] <= r_e2[3][i] * $signed({1'b0, r_q[i][QL-1:0]});
                r_mh[i] <= r_e2[3][i] * $signed(r_q[i][QW-1:QL]);
                r_nrm[4][i] <= sat_nrm(r_n[i]);

                r_dp[i] <= ((EW+PW)'(r_dh[i]) <<< PL) + (EW+PW)'(r_dl[i]);
                r_up[i] <= ((EW+PW)'(r_uh[i]) <<< PL) + (EW+PW)'(r_ul[i]);
                r_vp[i] <= ((DW+QW)'(r_vh[i]) <<< QL) + (DW+QW)'(r_vl[i]);
                r_mp[i] <= ((EW+QW)'(r_mh[i]) <<< QL) + (EW+QW)'(r_ml[i]);
                r_nrm[5][i] <= r_nrm[4][i];
                r_nrm[6][i] <= r_nrm[5][i];
                r_nrm[7][i] <= r_nrm[6][i];
            end

            r_det6 <= DETW'(r_dp[0]) + DETW'(r_dp[1]) + DETW'(r_dp[2]);
            r_u6   <= DETW'(r_up[0]) + DETW'(r_up[1]) + DETW'(r_up[2]);
            r_v6   <= DETW'(r_vp[0]) + DETW'(r_vp[1]) + DETW'(r_vp[2]);
            r_num6 <= NUMW'(r_mp[0]) + NUMW'(r_mp[1]) + NUMW'(r_mp[2]);

            r_hit7  <= hit6;
            r_sign7 <= r_num6[NUMW-1];
            r_det7  <= r_det6;
            r_mag7  <= r_num6[NUMW-1] ? NUMW'(-r_num6) : NUMW'(r_num6);
        end
    end

    assign o_hit  = r_hit7;
    assign o_sign = r_sign7;
    assign o_det  = r_det7;
    assign o_mag  = r_mag7;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_nrm[i] = r_nrm[7][i];
        end
    end

endmodule

@@ rtl/core/rth_back.sv @@
// Division pipeline: one quotient bit per stage, then saturation and miss values.
// Depends on rth_pkg; takes its work from the queue behind rth_front.
module rth_back
    import rth_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    output logic                              o_pop,
    input  logic                              i_hit,
    input  logic                              i_sign,
    input  logic [det_w(COORD_WIDTH)-1:0]     i_det,
    input  logic [num_w(COORD_WIDTH)-1:0]     i_mag,
    input  logic signed [NRM_W-1:0]           i_nrm [3],
    output logic                              o_valid,
    input  logic                              i_out_full,
    output logic                              o_hit,
    output logic [DIST_W-1:0]                 o_distance,
    output logic signed [NRM_W-1:0]           o_nrm [3]
);

    localparam int DETW = det_w(COORD_WIDTH);
    localparam int NUMW = num_w(COORD_WIDTH);
    localparam int MW   = (NUMW + FRAC_BITS > DETW + DIST_W) ? NUMW + FRAC_BITS
                                                             : DETW + DIST_W;
    localparam int SH   = DIST_W - FRAC_BITS;
    localparam int CMPW = (NUMW > DETW + SH) ? NUMW : DETW + SH;
    localparam int NSTG = DIST_W + 2;

    logic [NSTG-1:0] r_vld;
    logic            en;

    logic [DETW-1:0]          r_rem  [DIST_W+1];
    logic [DIST_W-1:0]        r_low  [DIST_W+1];
    logic [DIST_W-1:0]        r_quo  [DIST_W+1];
    logic [DETW-1:0]          r_det  [DIST_W+1];
    logic                     r_sgn  [DIST_W+1];
    logic                     r_ovf  [DIST_W+1];
    logic                     r_hit  [DIST_W+1];
    logic signed [NRM_W-1:0]  r_nrm  [DIST_W+1][3];
    logic                     r_hit_o;
    logic [DIST_W-1:0]        r_dist_o;
    logic signed [NRM_W-1:0]  r_nrm_o [3];

    logic [MW-1:0]     m_ext;
    logic              ovf;
    logic [DIST_W-1:0] dist_sat;

    assign en      = !(r_vld[NSTG-1] && i_out_full);
    assign o_pop   = en && !i_empty;
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], !i_empty};
        end
    end

    always_comb begin
        m_ext = MW'(i_mag) << FRAC_BITS;
        ovf   = CMPW'(i_mag) >= (CMPW'(i_det) << SH);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0] <= m_ext[DETW+DIST_W-1:DIST_W];
            r_low[0] <= m_ext[DIST_W-1:0];
            r_quo[0] <= '0;
            r_det[0] <= i_det;
            r_sgn[0] <= i_sign;
            r_ovf[0] <= ovf;
            r_hit[0] <= i_hit;
            for (int i = 0; i < 3; i++) begin
                r_nrm[0][i] <= i_nrm[i];
            end
        end
    end

    for (genvar k = 0; k < DIST_W; k++) begin : g_div
        logic [DETW-1:0] sh;
        logic            ge;

        always_comb begin
            sh = {r_rem[k][DETW-2:0], r_low[k][DIST_W-1]};
            ge = (sh >= r_det[k]);
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[k+1] <= ge ? sh - r_det[k] : sh;
                r_quo[k+1] <= {r_quo[k][DIST_W-2:0], ge};
                r_low[k+1] <= {r_low[k][DIST_W-2:0], 1'b0};
                r_det[k+1] <= r_det[k];
                r_sgn[k+1] <= r_sgn[k];
                r_ovf[k+1] <= r_ovf[k];
                r_hit[k+1] <= r_hit[k];
                for (int i = 0; i < 3; i++) begin
                    r_nrm[k+1][i] <= r_nrm[k][i];
                end
            end
        end
    end

    always_comb begin
        priority if (!r_hit[DIST_W]) begin
            dist_sat = DIST_MAX;
        end else if (r_ovf[DIST_W]) begin
            dist_sat = r_sgn[DIST_W] ? DIST_MIN : DIST_MAX;
        end else if (!r_sgn[DIST_W]) begin
            dist_sat = r_quo[DIST_W][DIST_W-1] ? DIST_MAX : r_quo[DIST_W];
        end else if (r_quo[DIST_W] > DIST_MIN) begin
            dist_sat = DIST_MIN;
        end else begin
            dist_sat = -r_quo[DIST_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit_o  <= r_hit[DIST_W];
            r_dist_o <= dist_sat;
            for (int i = 0; i < 3; i++) begin
                r_nrm_o[i] <= r_hit[DIST_W] ? r_nrm[DIST_W][i] : '0;
            end
        end
    end

    assign o_hit      = r_hit_o;
    assign o_distance = r_dist_o;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_nrm[i] = r_nrm_o[i];
        end
    end

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for ray_triangle_hit_distance: triangles go in through the queue port.
// A behavioral model of the fixed-point hit test predicts each result, and the results are checked in order.
// Depends on rth_pkg and the ray_triangle_hit_distance RTL.
module tb;
    import rth_pkg::*;

    typedef logic signed [255:0] wide_t;
    typedef wide_t vec3_t [3];
    typedef logic signed [IN_W-1:0] coord_t;
    typedef coord_t tri_t [9];

    typedef struct {
        logic                     hit;
        logic signed [DIST_W-1:0] dist_val;
        logic signed [NRM_W-1:0]  nrm [3];
    } hit_result_t;

    localparam int FRAC_W_SHIFT = 16;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [IN_W-1:0] i_cfg_data = '0;
    logic push = 1'b0;
    logic full;
    coord_t i_a_x = '0, i_a_y = '0, i_a_z = '0;
    coord_t i_b_x = '0, i_b_y = '0, i_b_z = '0;
    coord_t i_c_x = '0, i_c_y = '0, i_c_z = '0;
    logic empty;
    logic pop = 1'b0;
    logic o_hit;
    logic signed [DIST_W-1:0] o_distance;
    logic signed [NRM_W-1:0] o_normal_x, o_normal_y, o_normal_z;

    coord_t ray_org [3];
    logic signed [DIR_W-1:0] ray_dir [3];
    hit_result_t expected_hits [$];
    int errors = 0;
    int pop_hold = 0;
    int quiet_cycles = 0;
    bit no_gaps = 1'b0;

    ray_triangle_hit_distance dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic vec3_t cross3(input vec3_t a, input vec3_t b);
        vec3_t r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    function automatic wide_t dot3(input vec3_t a, input vec3_t b);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function automatic wide_t find_det(input tri_t v);
        vec3_t d, e1, e2;
        for (int i = 0; i < 3; i++) begin
            d[i] = ray_dir[i];
            e1[i] = wide_t'(v[3+i]) - wide_t'(v[i]);
            e2[i] = wide_t'(v[6+i]) - wide_t'(v[i]);
        end
        return dot3(e1, cross3(d, e2));
    endfunction

    function automatic hit_result_t predict_hit(input tri_t v);
        vec3_t d, e1, e2, t, p, q, n;
        wide_t det, u, w, num, mag, quo;
        hit_result_t r;
        for (int i = 0; i < 3; i++) begin
            d[i] = ray_dir[i];
            e1[i] = wide_t'(v[3+i]) - wide_t'(v[i]);
            e2[i] = wide_t'(v[6+i]) - wide_t'(v[i]);
            t[i] = wide_t'(ray_org[i]) - wide_t'(v[i]);
        end
        p = cross3(d, e2);
        det = dot3(e1, p);
        u = dot3(t, p);
        q = cross3(t, e1);
        w = dot3(d, q);
        r.hit = det > 0 && u >= 0 && u <= det && w >= 0 && u + w <= det;
        r.dist_val = DIST_MAX;
        r.nrm = '{default: '0};
        if (r.hit) begin
            num = dot3(e2, q);
            mag = num < 0 ? -num : num;
            quo = (mag <<< FRAC_W_SHIFT) / det;
            if (num < 0) quo = -quo;
            if (quo > wide_t'($signed(DIST_MAX))) r.dist_val = DIST_MAX;
            else if (quo < wide_t'($signed(DIST_MIN))) r.dist_val = DIST_MIN;
            else r.dist_val = quo[DIST_W-1:0];
            n = cross3(e1, e2);
            for (int i = 0; i < 3; i++) begin
                if (n[i] > wide_t'($signed(NRM_MAX))) r.nrm[i] = NRM_MAX;
                else if (n[i] < wide_t'($signed(NRM_MIN))) r.nrm[i] = NRM_MIN;
                else r.nrm[i] = n[i][NRM_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic coord_t jitter(input int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    always @(posedge i_clk) begin
        if (pop && !empty) begin
            if (expected_hits.size() == 0) begin
                $display("%0t: result with nothing expected: hit %0d dist %0d", $time, o_hit,
                         o_distance);
                errors++;
            end else begin
                hit_result_t e;
                e = expected_hits.pop_front();
                if (o_hit !== e.hit) begin
                    $display("%0t: hit expected %0d actual %0d", $time, e.hit, o_hit);
                    errors++;
                end
                if (o_distance !== e.dist_val) begin
                    $display("%0t: distance expected %0d actual %0d", $time, e.dist_val,
                             o_distance);
                    errors++;
                end
                if (o_normal_x !== e.nrm[0] || o_normal_y !== e.nrm[1]
                        || o_normal_z !== e.nrm[2]) begin
                    $display("%0t: normal expected %0d %0d %0d actual %0d %0d %0d", $time,
                             e.nrm[0], e.nrm[1], e.nrm[2], o_normal_x, o_normal_y, o_normal_z);
                    errors++;
                end
            end
        end
        if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
            pop <= 1'b0;
        end else begin
            pop <= no_gaps || $urandom_range(0, 9) < 7;
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("[ray_triangle_hit_distance] ERROR");
            $finish;
        end
    end

    task automatic wait_drain();
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [IN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ORIGIN_X: ray_org[0] = data;
            CFG_ORIGIN_Y: ray_org[1] = data;
            CFG_ORIGIN_Z: ray_org[2] = data;
            CFG_DIR_X:    ray_dir[0] = data[DIR_W-1:0];
            CFG_DIR_Y:    ray_dir[1] = data[DIR_W-1:0];
            CFG_DIR_Z:    ray_dir[2] = data[DIR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_ray(input coord_t ox, input coord_t oy, input coord_t oz,
                           input logic [IN_W-1:0] dx, input logic [IN_W-1:0] dy,
                           input logic [IN_W-1:0] dz);
        push <= 1'b0;
        wait_drain();
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_DIR_X, dx);
        write_reg(CFG_DIR_Y, dy);
        write_reg(CFG_DIR_Z, dz);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_tri(input tri_t v);
        int gap;
        {i_a_x, i_a_y, i_a_z} <= {v[0], v[1], v[2]};
        {i_b_x, i_b_y, i_b_z} <= {v[3], v[4], v[5]};
        {i_c_x, i_c_y, i_c_z} <= {v[6], v[7], v[8]};
        push <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        expected_hits.push_back(predict_hit(v));
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Builds a front-facing triangle around the point at distance t_raw along the ray.
    task automatic send_near_ray(input longint t_raw, input int span);
        tri_t v;
        coord_t tmp;
        logic signed [63:0] pt;
        for (int k = 0; k < 8; k++) begin
            for (int i = 0; i < 9; i++) begin
                pt = 64'(ray_org[i%3]) + ((64'(ray_dir[i%3]) * t_raw) >>> 16);
                v[i] = pt[IN_W-1:0] + jitter(span);
            end
            if (find_det(v) < 0) begin
                for (int i = 0; i < 3; i++) begin
                    tmp = v[3+i];
                    v[3+i] = v[6+i];
                    v[6+i] = tmp;
                end
            end
            if (predict_hit(v).hit) break;
        end
        send_tri(v);
    endtask

    task automatic send_noise();
        tri_t v;
        for (int i = 0; i < 9; i++) v[i] = $urandom();
        send_tri(v);
    endtask

    task automatic test_default_ray();
        send_tri('{5<<16, -1<<16, -1<<16, 5<<16, 1<<16, -1<<16, 5<<16, 0, 2<<16});
        send_tri('{5<<16, -1<<16, -1<<16, 5<<16, 0, 2<<16, 5<<16, 1<<16, -1<<16});
        send_tri('{-3<<16, -1<<16, -1<<16, -3<<16, 1<<16, -1<<16, -3<<16, 0, 2<<16});
        send_tri('{7<<16, 0, 0, 7<<16, 1<<16, 0, 7<<16, 0, 1<<16});
        send_tri('{7<<16, -1<<16, 0, 7<<16, 1<<16, 0, 7<<16, 0, 1<<16});
        send_tri('{4<<16, 0, -1<<16, 4<<16, 1<<16, 0, 4<<16, 0, 0});
        send_tri('{1<<16, 1<<16, 1<<16, 1<<16, 1<<16, 1<<16, 1<<16, 1<<16, 1<<16});
        send_tri('{1<<16, 0, 0, 2<<16, 0, 0, 3<<16, 0, 0});
        send_tri('{0, -1, -1, 0, 1, -1, 0, 0, 2});
        send_tri('{32'h7fffffff, -1, -1, 32'h7fffffff, 1, -1, 32'h7fffffff, 0, 2});
        send_tri('{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                   32'h80000000, 32'h7fffffff, 0, 32'h7fffffff});
        send_tri('{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                   32'h80000000, 32'h80000000, 0, 32'h7fffffff});
        send_tri('{32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
                   32'haaaaaaaa, 32'hffffffff, 32'h00000000, 32'h7fffffff});
        send_tri('{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                   32'h55555555, 32'h00000000, 32'hffffffff, 32'h80000000});
        send_tri('{32'h7fff0000, -1<<16, -1<<16, 32'h7fff0001, 1<<16, -1<<16,
                   32'h7fff0000, 0, 2<<16});
    endtask

    task automatic test_ray_extremes();
        set_ray(32'h7fffffff, 32'h80000000, 0, 32'h30000, 32'h10000, 32'h1ffff);
        repeat (3) send_near_ray(-40 <<< 16, 1 << 18);
        send_noise();
        set_ray(32'h80000000, 32'h7fffffff, 32'h12345678, 32'h10000, 32'h30000, 0);
        repeat (3) send_near_ray(1 <<< 20, 1 << 16);
        set_ray(0, 0, 0, 32'h00000, 32'h00000, 32'h00001);
        repeat (3) send_near_ray(1 <<< 30, 1 << 4);
        set_ray(1 << 16, -2 << 16, 3 << 16, 32'h0b505, 32'h0b505, 0);
        repeat (3) send_near_ray(10 <<< 16, 1 << 15);
    endtask

    task automatic test_backpressure();
        wait_drain();
        pop_hold <= 300;
        no_gaps = 1'b1;
        for (int i = 0; i < 80; i++) send_near_ray($urandom_range(1, 500) <<< 12, 1 << 17);
        push <= 1'b0;
        no_gaps = 1'b0;
        wait_drain();
        for (int i = 0; i < 20; i++) send_near_ray(50 <<< 16, 1 << 14);
        push <= 1'b0;
        wait_drain();
    endtask

    task automatic test_random();
        logic [IN_W-1:0] d [3];
        for (int n = 0; n < 280; n++) begin
            if (n % 80 == 0) begin
                for (int i = 0; i < 3; i++)
                    d[i] = $urandom_range(0, 3) == 0 ? $urandom() : jitter(65536);
                set_ray(jitter(1 << 24), jitter(1 << 24), jitter(1 << 24), d[0], d[1], d[2]);
                no_gaps = n == 160;
            end
            case ($urandom_range(0, 9))
                0, 1:    send_noise();
                2:       send_near_ray(jitter(1 << 22), 1 << 20);
                default: send_near_ray($urandom_range(0, 1 << 24), $urandom_range(1 << 10, 1 << 18));
            endcase
        end
        push <= 1'b0;
        no_gaps = 1'b0;
    endtask

    initial begin
        ray_org = '{default: '0};
        ray_dir = '{DIR_ONE, DIR_ZERO, DIR_ZERO};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_ray();
        test_ray_extremes();
        push <= 1'b0;
        test_backpressure();
        test_random();
        wait_drain();
        repeat (60) @(posedge i_clk);
        if (errors == 0 && expected_hits.size() == 0) begin
            $display("[ray_triangle_hit_distance] OK");
        end else begin
            $display("[ray_triangle_hit_distance] ERROR");
        end
        $finish;
    end
endmodule
